[rtl/core/priority_event_flag_scheduler_macros.svh]
// Assertion macros shared by the scheduler RTL
`ifndef PRIORITY_EVENT_FLAG_SCHEDULER_MACROS_SVH
`define PRIORITY_EVENT_FLAG_SCHEDULER_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset
`define PEFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, clocked on clk, disabled in reset
`define PEFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[rtl/core/pefs_pkg.sv]
// Types and constants shared by the event-flag scheduler
`timescale 1ns / 1ps

package pefs_pkg;

    localparam int MODE_W   = 2;
    localparam int TID_W    = 8;
    localparam int EVT_W    = 16;
    localparam int STAT_W   = 2;
    localparam int CTASK_W  = 4;
    localparam int TIU_W    = 5;
    localparam logic [TIU_W-1:0] TIU_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET      = 2'd0,
        MODE_CLEAR    = 2'd1,
        MODE_DISPATCH = 2'd2,
        MODE_RETURN   = 2'd3
    } mode_t;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_BAD_ID = 2'd1;
    localparam status_t STATUS_IDLE   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/pefs_if.sv]
// Channel interfaces: request, response and configuration write
`timescale 1ns / 1ps

interface pefs_req_if;
    import pefs_pkg::*;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [TID_W-1:0]   task_id;
    logic [EVT_W-1:0]   event_mask;

    modport source (output valid, mode, task_id, event_mask, input ready);
    modport sink   (input valid, mode, task_id, event_mask, output ready);
endinterface

interface pefs_rsp_if;
    import pefs_pkg::*;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [CTASK_W-1:0] chosen_task;
    logic [EVT_W-1:0]   chosen_events;

    modport source (output valid, status, chosen_task, chosen_events, input ready);
    modport sink   (input valid, status, chosen_task, chosen_events, output ready);
endinterface

interface pefs_cfg_if;
    import pefs_pkg::*;
    logic               valid;
    logic               ready;
    logic [TIU_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/pefs_datapath.sv]
// Datapath: event word memory, nonzero flags, priority pick and response register
`timescale 1ns / 1ps

module pefs_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pefs_pkg::ctrl_cmd_t         cmd,
    output pefs_pkg::dp_status_t        stat,
    input  logic [pefs_pkg::MODE_W-1:0] mode,
    input  logic [pefs_pkg::TID_W-1:0]  task_id,
    input  logic [pefs_pkg::EVT_W-1:0]  event_mask,
    pefs_cfg_if.sink                    cfg,
    pefs_rsp_if.source                  rsp
);
    import pefs_pkg::*;

    `include "priority_event_flag_scheduler_macros.svh"

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [TID_W-1:0] MAX_VAL = TID_W'(MAX_TASKS);

    logic [TIU_W-1:0]   tiu_reg;

    mode_t              mode_reg;
    logic [TID_W-1:0]   id_reg;
    logic [EVT_W-1:0]   mask_reg;

    logic [MAX_TASKS-1:0] nz_reg;
    logic [EVT_W-1:0]   mem [MAX_TASKS];
    logic [EVT_W-1:0]   rdata_reg;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    status_t            st_reg, st_next;

    logic               rsp_valid_reg;
    status_t            rsp_status_reg;
    logic [CTASK_W-1:0] rsp_task_reg;
    logic [EVT_W-1:0]   rsp_events_reg;

    logic [TID_W-1:0]   eff_count;
    logic [MAX_TASKS-1:0] in_use;
    logic [MAX_TASKS-1:0] cand;
    logic [IDX_W-1:0]   pick;
    logic [EVT_W-1:0]   word;
    logic [EVT_W-1:0]   new_word;
    logic               wr_en;
    logic               is_dispatch;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiu_reg <= TIU_RESET;
        end
        else if (cfg.valid)
        begin
            tiu_reg <= cfg.data;
        end
    end

    // Latch the request on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode_t'(mode);
            id_reg   <= task_id;
            mask_reg <= event_mask;
        end
    end

    // Effective task count and in-use slots
    always_comb
    begin
        if (TID_W'(tiu_reg) > MAX_VAL)
            eff_count = MAX_VAL;
        else
            eff_count = TID_W'(tiu_reg);
    end

    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_use
        assign in_use[g] = (TID_W'(g) < eff_count);
    end

    assign cand = nz_reg & in_use;

    // Lowest-numbered pending task
    always_comb
    begin
        pick = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (cand[i])
                pick = IDX_W'(i);
        end
    end

    assign is_dispatch = (mode_reg == MODE_DISPATCH);

    always_comb
    begin
        if (is_dispatch)
        begin
            idx_next = pick;
            st_next  = (|cand) ? STATUS_OK : STATUS_IDLE;
        end
        else
        begin
            idx_next = id_reg[IDX_W-1:0];
            st_next  = (id_reg >= eff_count) ? STATUS_BAD_ID : STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            idx_reg <= idx_next;
            st_reg  <= st_next;
        end
    end

    // A slot with its flag clear holds zero regardless of memory contents
    assign word = nz_reg[idx_reg] ? rdata_reg : '0;

    always_comb
    begin
        unique case (mode_reg)
            MODE_SET, MODE_RETURN: new_word = word | mask_reg;
            MODE_CLEAR:            new_word = word & ~mask_reg;
            MODE_DISPATCH:         new_word = '0;
            default:               new_word = word;
        endcase
    end

    assign wr_en = cmd.update && (st_reg == STATUS_OK);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= new_word;
        if (cmd.lookup)
            rdata_reg <= mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg <= '0;
        end
        else if (wr_en)
        begin
            nz_reg[idx_reg] <= |new_word;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rsp_status_reg <= st_reg;
            if (is_dispatch && (st_reg == STATUS_OK))
            begin
                rsp_task_reg   <= CTASK_W'(idx_reg);
                rsp_events_reg <= word;
            end
            else
            begin
                rsp_task_reg   <= '0;
                rsp_events_reg <= '0;
            end
        end
    end

    assign stat.out_free     = !rsp_valid_reg || rsp.ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.chosen_task   = rsp_task_reg;
    assign rsp.chosen_events = rsp_events_reg;

    `PEFS_ASSERT_NEXT(a_update_gives_rsp, cmd.update, rsp.valid)
    `PEFS_ASSERT_NOW(a_fail_rsp_zero, rsp.valid && (rsp.status != STATUS_OK),
                     (rsp.chosen_task == '0) && (rsp.chosen_events == '0))

endmodule

[rtl/core/pefs_ctrl.sv]
// Controller: sequences capture, lookup and update per transaction
`timescale 1ns / 1ps

module pefs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  pefs_pkg::dp_status_t stat,
    output pefs_pkg::ctrl_cmd_t  cmd
);
    import pefs_pkg::*;

    `include "priority_event_flag_scheduler_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // Take a new request while idle, or as the current one retires
    assign req_ready   = (state_reg == ST_IDLE) ||
                         ((state_reg == ST_UPDATE) && stat.out_free);
    assign accept      = req_valid && req_ready;
    assign cmd.capture = accept;
    assign cmd.lookup  = (state_reg == ST_LOOKUP);
    assign cmd.update  = (state_reg == ST_UPDATE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (stat.out_free)
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `PEFS_ASSERT_NEXT(a_accept_to_lookup, accept, state_reg == ST_LOOKUP)
    `PEFS_ASSERT_NEXT(a_lookup_to_update, state_reg == ST_LOOKUP, state_reg == ST_UPDATE)

endmodule

[rtl/core/priority_event_flag_scheduler.sv]
// Top level of the priority event-flag task scheduler
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+--------------------------------------
//  req     | in  | valid / ready  | mode, task_id, event_mask
//  rsp     | out | valid / ready  | status, chosen_task, chosen_events
//  cfg     | in  | valid / ready  | data = tasks_in_use (always ready)
//
// Each transaction runs a lookup cycle (priority pick over the nonzero flags
// and the event-word memory read) followed directly by an update cycle
// (read-modify-write of the word); the response is valid the cycle after update.
// Reset clears the nonzero flags at once and loads tasks_in_use = 16; no
// clearing pass is needed, a slot with its flag clear reads as zero.
// A stalled response holds the update cycle and with it req.ready.
`timescale 1ns / 1ps

module priority_event_flag_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    pefs_cfg_if.sink    cfg,
    pefs_req_if.sink    req,
    pefs_rsp_if.source  rsp
);
    import pefs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;
    logic       req_ready;

    // Controller owns the request handshake
    pefs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (dp_stat),
        .cmd       (cmd)
    );

    assign req.ready = req_ready;

    // Datapath holds the event words, the count register and the response
    pefs_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (dp_stat),
        .mode       (req.mode),
        .task_id    (req.task_id),
        .event_mask (req.event_mask),
        .cfg        (cfg),
        .rsp        (rsp)
    );

endmodule
